// File: sv/tdq_pkg.sv
// ----------------------------------------------------------------------------
// tdq_pkg
// Shared types and codes for the tagged dispatch queue: command codes,
// entry states and the packed layout of one queue entry.
// ----------------------------------------------------------------------------
package tdq_pkg;

  localparam int TAG_W  = 6;
  localparam int ADDR_W = 64;

  typedef logic [1:0]        cmd_t;
  typedef logic [1:0]        est_t;
  typedef logic [TAG_W-1:0]  tag_t;
  typedef logic [ADDR_W-1:0] addr_t;

  // command codes
  localparam cmd_t CMD_ADD    = 2'd0;
  localparam cmd_t CMD_REMOVE = 2'd1;
  localparam cmd_t CMD_STATUS = 2'd2;
  localparam cmd_t CMD_TAKE   = 2'd3;

  // entry state codes reported on entry_state
  localparam est_t EST_NULL    = 2'd0;
  localparam est_t EST_PENDING = 2'd1;
  localparam est_t EST_RUNNING = 2'd2;
  localparam est_t EST_ERROR   = 2'd3;

  // one queue slot as stored in the entry memory
  typedef struct packed {
    tag_t  tag;
    logic  running;
    addr_t addr;
  } entry_t;

endpackage

// File: sv/tdq_ram.sv
// ----------------------------------------------------------------------------
// tdq_ram
// Generic single-write, single-read synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module tdq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: sv/tagged_dispatch_queue_unit.sv
// ----------------------------------------------------------------------------
// tagged_dispatch_queue_unit
// Ordered table of tagged work entries held in one entry RAM. Add appends,
// remove erases the earliest match and closes the gap, status looks up the
// earliest match, take-next marks the first pending entry as running.
//
//   channel   handshake          fields
//   -------   ----------------   ---------------------------------------------
//   command   start / busy       cmd, work_address, query_tag
//   result    done (one cycle)   accepted, entry_state, result_tag,
//                                result_address
//
// add, and any command on an empty table: result in the cycle after the beat.
// status and take-next walk the RAM one slot a cycle.
// remove walks to the match, then moves each later slot down one place
// through the single read port.
// busy is high while a walk is in progress; results cannot be held off.
// synchronous reset empties the table and clears the tag counter.
// ----------------------------------------------------------------------------
module tagged_dispatch_queue_unit #(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  tdq_pkg::cmd_t   cmd,
  input  tdq_pkg::addr_t  work_address,
  input  tdq_pkg::tag_t   query_tag,
  output logic            done,
  output logic            accepted,
  output tdq_pkg::est_t   entry_state,
  output tdq_pkg::tag_t   result_tag,
  output tdq_pkg::addr_t  result_address
);

  import tdq_pkg::*;

  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;

  logic [1:0]    state, state_next;
  logic [CW-1:0] occupancy, occupancy_next;
  tag_t          tag_counter, tag_counter_next;
  logic [CW-1:0] ridx, ridx_next;
  logic          pend, pend_next;
  logic [CW-1:0] pidx, pidx_next;
  cmd_t          op, op_next;
  tag_t          qtag, qtag_next;

  logic          done_next;
  logic          accepted_next;
  est_t          entry_state_next;
  tag_t          result_tag_next;
  addr_t         result_address_next;

  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  entry_t        ram_wdata;
  logic [IW-1:0] ram_raddr;
  logic [$bits(entry_t)-1:0] ram_rdata;
  entry_t        rd_entry;

  logic          issue;
  logic          match;
  logic [CW-1:0] pidx_dec;
  tag_t          tag_inc;

  assign busy     = (state != S_IDLE);
  assign rd_entry = entry_t'(ram_rdata);
  assign issue    = (ridx < occupancy);
  assign pidx_dec = pidx - CW'(1);
  assign tag_inc  = tag_counter + TAG_W'(1);
  assign match    = pend && ((op == CMD_TAKE) ? !rd_entry.running
                                              : (rd_entry.tag == qtag));

  // entry memory
  tdq_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // command sequencer
  always_comb begin
    state_next          = state;
    occupancy_next      = occupancy;
    tag_counter_next    = tag_counter;
    ridx_next           = ridx;
    pend_next           = pend;
    pidx_next           = pidx;
    op_next             = op;
    qtag_next           = qtag;
    done_next           = 1'b0;
    accepted_next       = accepted;
    entry_state_next    = entry_state;
    result_tag_next     = result_tag;
    result_address_next = result_address;
    ram_we              = 1'b0;
    ram_waddr           = occupancy[IW-1:0];
    ram_wdata.tag       = tag_inc;
    ram_wdata.running   = 1'b0;
    ram_wdata.addr      = work_address;
    ram_raddr           = ridx[IW-1:0];

    case (state)
      S_IDLE: begin
        if (start) begin
          op_next             = cmd;
          qtag_next           = query_tag;
          accepted_next       = 1'b0;
          entry_state_next    = EST_NULL;
          result_tag_next     = '0;
          result_address_next = '0;
          if (cmd == CMD_ADD) begin
            done_next = 1'b1;
            if (occupancy < CW'(QUEUE_DEPTH)) begin
              ram_we           = 1'b1;
              tag_counter_next = tag_inc;
              occupancy_next   = occupancy + CW'(1);
              accepted_next    = 1'b1;
              result_tag_next  = tag_inc;
            end
          end else if (occupancy == '0) begin
            done_next = 1'b1;
            if (cmd == CMD_STATUS) begin
              entry_state_next = EST_ERROR;
            end
          end else begin
            state_next = S_SCAN;
            ridx_next  = '0;
            pend_next  = 1'b0;
          end
        end
      end

      S_SCAN: begin
        // issue one read a cycle, check the slot that returns
        pend_next = issue;
        pidx_next = ridx;
        if (issue) begin
          ridx_next = ridx + CW'(1);
        end
        if (match) begin
          case (op)
            CMD_REMOVE: begin
              state_next = S_SHIFT;
              ridx_next  = pidx + CW'(1);
              pend_next  = 1'b0;
            end
            CMD_STATUS: begin
              state_next       = S_IDLE;
              done_next        = 1'b1;
              entry_state_next = rd_entry.running ? EST_RUNNING : EST_PENDING;
            end
            default: begin
              ram_we                = 1'b1;
              ram_waddr             = pidx[IW-1:0];
              ram_wdata             = rd_entry;
              ram_wdata.running     = 1'b1;
              state_next            = S_IDLE;
              done_next             = 1'b1;
              entry_state_next      = EST_RUNNING;
              result_tag_next       = rd_entry.tag;
              result_address_next   = rd_entry.addr;
            end
          endcase
        end else if (!issue) begin
          // walked every slot without a match
          state_next = S_IDLE;
          done_next  = 1'b1;
          if (op != CMD_REMOVE) begin
            entry_state_next = EST_ERROR;
          end
        end
      end

      S_SHIFT: begin
        // read slot i, write it back at slot i - 1
        pend_next = issue;
        pidx_next = ridx;
        if (issue) begin
          ridx_next = ridx + CW'(1);
        end
        if (pend) begin
          ram_we    = 1'b1;
          ram_waddr = pidx_dec[IW-1:0];
          ram_wdata = rd_entry;
        end
        if (!issue && !pend) begin
          occupancy_next = occupancy - CW'(1);
          state_next     = S_IDLE;
          done_next      = 1'b1;
          accepted_next  = 1'b1;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      occupancy   <= '0;
      tag_counter <= '0;
      pend        <= 1'b0;
      done        <= 1'b0;
    end else begin
      state       <= state_next;
      occupancy   <= occupancy_next;
      tag_counter <= tag_counter_next;
      pend        <= pend_next;
      done        <= done_next;
    end
  end

  // walk pointers, latched command and result beat
  always_ff @(posedge clk) begin
    ridx           <= ridx_next;
    pidx           <= pidx_next;
    op             <= op_next;
    qtag           <= qtag_next;
    accepted       <= accepted_next;
    entry_state    <= entry_state_next;
    result_tag     <= result_tag_next;
    result_address <= result_address_next;
  end

  // occupancy stays within the table
  assert property (@(posedge clk) disable iff (rst)
    occupancy <= CW'(QUEUE_DEPTH))
    else $error("occupancy beyond table depth");

  // a result beat is only shown once the walk has ended
  assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result beat while busy");

  // during a search only take-next writes the memory
  assert property (@(posedge clk) disable iff (rst)
    (ram_we && state == S_SCAN) |-> (op == CMD_TAKE))
    else $error("unexpected memory write during search");

  // occupancy only changes together with a result beat
  assert property (@(posedge clk) disable iff (rst)
    (occupancy != occupancy_next) |=> done)
    else $error("occupancy changed without a result");

endmodule
